### rtl/fln_pkg.sv
`default_nettype none

package fln_pkg;

    // Default number of fraction bits of the internal vector format.
    localparam int FRAC_BITS_DEF = 16;

    // Background marker: a pure blue pixel under the light from above.
    localparam logic [7:0] BG_RED   = 8'd0;
    localparam logic [7:0] BG_GREEN = 8'd0;
    localparam logic [7:0] BG_BLUE  = 8'd255;

    typedef struct packed {
        logic [7:0] up_red;
        logic [7:0] up_green;
        logic [7:0] up_blue;
        logic [7:0] down_red;
        logic [7:0] left_red;
        logic [7:0] right_red;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] normal_x_byte;
        logic [7:0] normal_y_byte;
        logic [7:0] normal_z_byte;
    } normal_out_t;

    // Integer square root, evaluated only while building constant tables.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bw;
        rem = v;
        res = '0;
        bw  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bw) begin
                rem = rem - (res + bw);
                res = (res >> 1) + bw;
            end else begin
                res = res >> 1;
            end
            bw = bw >> 2;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/fln_front.sv
`default_nettype none

module fln_front
    import fln_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire pixel_in_t                     pixel,
    output logic                               out_valid,
    output logic [3*(FRAC_BITS+4)-1:0]         vec,
    output logic [2*(FRAC_BITS+3)-1:0]         norm2
);

    localparam int VW  = FRAC_BITS + 4;
    localparam int TW  = FRAC_BITS + 1;
    localparam int N2W = 2 * (FRAC_BITS + 3);

    typedef logic [TW-1:0] tab_t [256];

    // floor(sqrt(1 - (r/255)^2) * 2^F) for every red level.
    function automatic tab_t build_root();
        tab_t        tab;
        logic [63:0] a;
        for (int r = 0; r < 256; r++) begin
            a      = 64'(65025 - r * r) << (2 * FRAC_BITS);
            tab[r] = TW'(isqrt64(a) / 64'd255);
        end
        return tab;
    endfunction

    // floor(d * 2^F / 255) for every difference magnitude.
    function automatic tab_t build_frac();
        tab_t tab;
        for (int d = 0; d < 256; d++) begin
            tab[d] = TW'((64'(d) << FRAC_BITS) / 64'd255);
        end
        return tab;
    endfunction

    localparam tab_t ROOT_TAB = build_root();
    localparam tab_t FRAC_TAB = build_frac();
    localparam logic signed [VW-1:0] MINUS_ONE = -(VW'(1) <<< FRAC_BITS);

    // Stage 1: table lookups.
    logic          s1_vld_reg;
    logic          s1_bg_reg;
    logic          s1_sx_reg, s1_sy_reg;
    logic [TW-1:0] s1_fx_reg, s1_fy_reg;
    logic [TW-1:0] s1_ru_reg, s1_rd_reg, s1_rl_reg, s1_rr_reg;

    logic       sx_next, sy_next;
    logic [7:0] ax_next, ay_next;

    always_comb
    begin
        sx_next = pixel.right_red < pixel.left_red;
        sy_next = pixel.down_red < pixel.up_red;
        ax_next = sx_next ? pixel.left_red - pixel.right_red : pixel.right_red - pixel.left_red;
        ay_next = sy_next ? pixel.up_red - pixel.down_red : pixel.down_red - pixel.up_red;
    end

    // Stage 2: signed components.
    logic                 s2_vld_reg;
    logic signed [VW-1:0] s2_vx_reg, s2_vy_reg, s2_vz_reg;
    logic signed [VW-1:0] vx_next, vy_next, vz_next;

    always_comb
    begin
        if (s1_bg_reg)
        begin
            vx_next = MINUS_ONE;
            vy_next = MINUS_ONE;
            vz_next = MINUS_ONE;
        end else begin
            vx_next = s1_sx_reg ? -VW'(s1_fx_reg) : VW'(s1_fx_reg);
            vy_next = s1_sy_reg ? -VW'(s1_fy_reg) : VW'(s1_fy_reg);
            vz_next = VW'(s1_ru_reg) + VW'(s1_rd_reg) + VW'(s1_rl_reg) + VW'(s1_rr_reg);
        end
    end

    // Stage 3: squares. Stage 4: sum of squares.
    logic                   s3_vld_reg;
    logic signed [VW-1:0]   s3_vx_reg, s3_vy_reg, s3_vz_reg;
    logic [N2W-1:0]         s3_qx_reg, s3_qy_reg, s3_qz_reg;
    logic signed [2*VW-1:0] px_next, py_next, pz_next;

    assign px_next = s2_vx_reg * s2_vx_reg;
    assign py_next = s2_vy_reg * s2_vy_reg;
    assign pz_next = s2_vz_reg * s2_vz_reg;

    logic                 s4_vld_reg;
    logic [3*VW-1:0]      s4_vec_reg;
    logic [N2W-1:0]       s4_n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bg_reg  <= (pixel.up_red == BG_RED) && (pixel.up_green == BG_GREEN)
                      && (pixel.up_blue == BG_BLUE);
        s1_sx_reg  <= sx_next;
        s1_sy_reg  <= sy_next;
        s1_fx_reg  <= FRAC_TAB[ax_next];
        s1_fy_reg  <= FRAC_TAB[ay_next];
        s1_ru_reg  <= ROOT_TAB[pixel.up_red];
        s1_rd_reg  <= ROOT_TAB[pixel.down_red];
        s1_rl_reg  <= ROOT_TAB[pixel.left_red];
        s1_rr_reg  <= ROOT_TAB[pixel.right_red];

        s2_vx_reg  <= vx_next;
        s2_vy_reg  <= vy_next;
        s2_vz_reg  <= vz_next;

        s3_vx_reg  <= s2_vx_reg;
        s3_vy_reg  <= s2_vy_reg;
        s3_vz_reg  <= s2_vz_reg;
        s3_qx_reg  <= px_next[N2W-1:0];
        s3_qy_reg  <= py_next[N2W-1:0];
        s3_qz_reg  <= pz_next[N2W-1:0];

        s4_vec_reg <= {s3_vx_reg, s3_vy_reg, s3_vz_reg};
        s4_n2_reg  <= s3_qx_reg + s3_qy_reg + s3_qz_reg;
    end

    assign out_valid = s4_vld_reg;
    assign vec       = s4_vec_reg;
    assign norm2     = s4_n2_reg;

endmodule

`default_nettype wire

### rtl/fln_sqrt.sv
`default_nettype none

module fln_sqrt
    import fln_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [2*(FRAC_BITS+3)-1:0]    radicand,
    input  wire logic [3*(FRAC_BITS+4)-1:0]    vec_in,
    output logic                               out_valid,
    output logic [FRAC_BITS+2:0]               root,
    output logic [3*(FRAC_BITS+4)-1:0]         vec_out
);

    localparam int VW  = FRAC_BITS + 4;
    localparam int RW  = FRAC_BITS + 3;
    localparam int N2W = 2 * RW;

    // One root bit per stage, restoring method, most significant bit first.
    logic            vld_reg  [RW];
    logic [N2W-1:0]  rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [3*VW-1:0] vec_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic            vld_prev;
        logic [N2W-1:0]  rad_prev;
        logic [RW+1:0]   rem_prev;
        logic [RW-1:0]   root_prev;
        logic [3*VW-1:0] vec_prev;
        logic [RW+1:0]   rem_sh;
        logic [RW+1:0]   trial;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign vec_prev  = vec_in;
        end else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign vec_prev  = vec_reg[k-1];
        end

        assign rem_sh = {rem_prev[RW-1:0], rad_prev[N2W-1 -: 2]};
        assign trial  = {root_prev, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end else begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k] <= rad_prev << 2;
            vec_reg[k] <= vec_prev;
            if (rem_sh >= trial)
            begin
                rem_reg[k]  <= rem_sh - trial;
                root_reg[k] <= {root_prev[RW-2:0], 1'b1};
            end else begin
                rem_reg[k]  <= rem_sh;
                root_reg[k] <= {root_prev[RW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign vec_out   = vec_reg[RW-1];

endmodule

`default_nettype wire

### rtl/fln_div.sv
`default_nettype none

module fln_div
    import fln_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [FRAC_BITS+2:0]          divisor,
    input  wire logic [3*(FRAC_BITS+4)-1:0]    vec_in,
    output logic                               out_valid,
    output logic                               div_zero,
    output logic [2:0]                         neg,
    output logic [3*(FRAC_BITS+2)-1:0]         quot
);

    localparam int VW = FRAC_BITS + 4;
    localparam int RW = FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 2;
    localparam int MW = FRAC_BITS + 3;

    // Three lanes share the divisor; each stage settles one quotient bit of
    // |v| * 2^F / n, most significant bit first.
    logic          vld_reg [QW];
    logic [RW-1:0] n_reg   [QW];
    logic [2:0]    neg_reg [QW];
    logic [RW:0]   rem_reg [QW][3];
    logic [QW-1:0] low_reg [QW][3];
    logic [QW-1:0] q_reg   [QW][3];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          vld_prev;
        logic [RW-1:0] n_prev;
        logic [2:0]    neg_prev;

        if (k == 0)
        begin : g_first
            assign vld_prev = in_valid;
            assign n_prev   = divisor;
            for (genvar j = 0; j < 3; j++)
            begin : g_sign
                assign neg_prev[j] = vec_in[(3-j)*VW-1];
            end
        end else begin : g_rest
            assign vld_prev = vld_reg[k-1];
            assign n_prev   = n_reg[k-1];
            assign neg_prev = neg_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end else begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]   <= n_prev;
            neg_reg[k] <= neg_prev;
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [RW:0]   rem_prev;
            logic [QW-1:0] low_prev;
            logic [QW-1:0] q_prev;
            logic [RW:0]   rem_sh;

            if (k == 0)
            begin : g_first
                logic signed [VW-1:0] v;
                logic signed [VW-1:0] v_abs;
                logic [MW-1:0]        mag;
                assign v        = vec_in[(2-j)*VW +: VW];
                assign v_abs    = v[VW-1] ? -v : v;
                assign mag      = v_abs[MW-1:0];
                assign rem_prev = (RW+1)'(mag[MW-1:2]);
                assign low_prev = {mag[1:0], {FRAC_BITS{1'b0}}};
                assign q_prev   = '0;
            end else begin : g_rest
                assign rem_prev = rem_reg[k-1][j];
                assign low_prev = low_reg[k-1][j];
                assign q_prev   = q_reg[k-1][j];
            end

            assign rem_sh = {rem_prev[RW-1:0], low_prev[QW-1]};

            always_ff @(posedge clk)
            begin
                low_reg[k][j] <= low_prev << 1;
                if (rem_sh >= {1'b0, n_prev})
                begin
                    rem_reg[k][j] <= rem_sh - {1'b0, n_prev};
                    q_reg[k][j]   <= {q_prev[QW-2:0], 1'b1};
                end else begin
                    rem_reg[k][j] <= rem_sh;
                    q_reg[k][j]   <= {q_prev[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign div_zero  = (n_reg[QW-1] == '0);
    assign neg       = neg_reg[QW-1];
    assign quot      = {q_reg[QW-1][0], q_reg[QW-1][1], q_reg[QW-1][2]};

endmodule

`default_nettype wire

### rtl/four_light_shading_to_normal_pixel_core.sv
// Channel   Ports                     Beat taken when
// --------  ------------------------  ---------------------------------
// pixel in  start, busy, pixel        start high and busy low at clk rise
// normal    valid, normal             valid high, one cycle, never held
//
// One pixel may be started in every cycle while busy is low. Each beat
// passes through four front stages, the root extractor (FRAC_BITS+3
// stages, one root bit each), the three-lane divider (FRAC_BITS+2 stages,
// one quotient bit each) and two encode stages before it comes out on the
// normal port.
// Reset is asynchronous and clears every valid bit; busy is high during
// reset, drops at the first clock edge after it and stays low from then on.
// The receiver cannot stall, so the pipeline never holds and never drops.
`default_nettype none

module four_light_shading_to_normal_pixel_core
    import fln_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire pixel_in_t   pixel,
    output logic             valid,
    output normal_out_t      normal
);

    localparam int VW = FRAC_BITS + 4;
    localparam int RW = FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 2;
    localparam int SW = QW + 1;
    localparam int TW = QW + 9;

    // The encode bias 127 * 2^F in the widened format.
    localparam logic signed [TW-1:0] BIAS = TW'(127) <<< FRAC_BITS;

    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end else begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // The front end forms the vector (x, y, z) and its squared length.
    logic                   f_vld;
    logic [3*VW-1:0]        f_vec;
    logic [2*RW-1:0]        f_n2;

    fln_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (f_vld),
        .vec       (f_vec),
        .norm2     (f_n2)
    );

    // The vector rides along with the length while its root is extracted.
    logic                   s_vld;
    logic [RW-1:0]          s_root;
    logic [3*VW-1:0]        s_vec;

    fln_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld),
        .radicand  (f_n2),
        .vec_in    (f_vec),
        .out_valid (s_vld),
        .root      (s_root),
        .vec_out   (s_vec)
    );

    // Each component magnitude is divided by the length; signs travel apart.
    logic                   d_vld;
    logic                   d_zero;
    logic [2:0]             d_neg;
    logic [3*QW-1:0]        d_quot;

    fln_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_vld),
        .divisor   (s_root),
        .vec_in    (s_vec),
        .out_valid (d_vld),
        .div_zero  (d_zero),
        .neg       (d_neg),
        .quot      (d_quot)
    );

    // Encode stage one restores the sign and maps a zero length to a zero
    // vector. Stage two scales by 128, adds the bias, drops the fraction and clamps.
    logic                 e1_vld_reg;
    logic signed [SW-1:0] e1_q_reg [3];
    logic                 e2_vld_reg;
    logic [7:0]           e2_byte_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
        end else begin
            e1_vld_reg <= d_vld;
            e2_vld_reg <= e1_vld_reg;
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_enc
        logic signed [SW-1:0] q_mag;
        logic signed [SW-1:0] q_next;
        logic signed [TW-1:0] t;
        logic [7:0]           byte_next;

        assign q_mag = SW'(d_quot[(2-j)*QW +: QW]);

        always_comb
        begin
            if (d_zero)
            begin
                q_next = '0;
            end else if (d_neg[j]) begin
                q_next = -q_mag;
            end else begin
                q_next = q_mag;
            end
        end

        assign t = (TW'(e1_q_reg[j]) <<< 7) + BIAS;

        always_comb
        begin
            if (t[TW-1])
            begin
                byte_next = 8'd0;
            end else if (|t[TW-2:FRAC_BITS+8]) begin
                byte_next = 8'd255;
            end else begin
                byte_next = t[FRAC_BITS+7:FRAC_BITS];
            end
        end

        always_ff @(posedge clk)
        begin
            e1_q_reg[j]    <= q_next;
            e2_byte_reg[j] <= byte_next;
        end
    end

    assign valid                = e2_vld_reg;
    assign normal.normal_x_byte = e2_byte_reg[0];
    assign normal.normal_y_byte = e2_byte_reg[1];
    assign normal.normal_z_byte = e2_byte_reg[2];

endmodule

`default_nettype wire

### rtl/fln_checker.sv
`default_nettype none

module fln_checker
    import fln_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire pixel_in_t   pixel,
    input  wire logic        valid,
    input  wire normal_out_t normal
);

    localparam int LAT = 2 * FRAC_BITS + 11;

    logic accept;
    logic is_bg;
    logic all_lit;

    assign accept  = start && !busy;
    assign is_bg   = (pixel.up_red == BG_RED) && (pixel.up_green == BG_GREEN)
                     && (pixel.up_blue == BG_BLUE);
    assign all_lit = (pixel.up_red == 8'd255) && (pixel.down_red == 8'd255)
                     && (pixel.left_red == 8'd255) && (pixel.right_red == 8'd255);

    // Every started beat comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT valid)
        else $error("started beat did not come out on time");

    // No result beat appears without a beat started at the matching time.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(accept, LAT))
        else $error("result beat without a started beat");

    // A background pixel normalizes (-1,-1,-1) to bytes of 53.
    a_background: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_bg) |-> ##LAT (normal.normal_x_byte == 8'd53
            && normal.normal_y_byte == 8'd53 && normal.normal_z_byte == 8'd53))
        else $error("background pixel gave a wrong normal");

    // Four saturated reds give a zero vector, which encodes as 127.
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && all_lit) |-> ##LAT (normal.normal_x_byte == 8'd127
            && normal.normal_y_byte == 8'd127 && normal.normal_z_byte == 8'd127))
        else $error("zero vector gave a wrong normal");

endmodule

bind four_light_shading_to_normal_pixel_core fln_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_fln_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .valid  (valid),
    .normal (normal)
);

`default_nettype wire

### bench/four_light_shading_to_normal_pixel_core_tb.sv
`timescale 1ns / 1ps

module four_light_shading_to_normal_pixel_core_tb
    import fln_pkg::*;
;

    localparam int FRAC = FRAC_BITS_DEF;
    // Pipeline depth of the core, from the stages listed at its head.
    localparam int LATENCY = 2 * FRAC + 11;

    // The scoreboard holds the normals that the core still owes us, in the
    // order their pixels were taken. Each accepted pixel is run through a
    // bit-exact integer model of the shading-to-normal conversion.
    class normal_scoreboard;
        normal_out_t owed_normals[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Integer square root, floor, by trying one result bit at a time.
        static function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned cand;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (cand * cand <= v)
                    root = cand;
            end
            return root;
        endfunction

        // sqrt(1 - (r/255)^2) in Q.FRAC, floored.
        static function longint shade_root(logic [7:0] r);
            longint unsigned a;
            a = 65025 - longint'(r) * longint'(r);
            return longint'(floor_sqrt(a << (2 * FRAC)) / 255);
        endfunction

        // Normalize one component and map it to trunc(c*128+127), clamped.
        static function logic [7:0] encode_component(longint v, longint n);
            longint q;
            longint t;
            q = 0;
            if (n != 0)
                q = (v * (longint'(1) << FRAC)) / n;
            t = q * 128 + 127 * (longint'(1) << FRAC);
            if (t < 0)
                return 8'd0;
            t = t >>> FRAC;
            if (t > 255)
                t = 255;
            return t[7:0];
        endfunction

        function void note_pixel(pixel_in_t p);
            longint one;
            longint vx;
            longint vy;
            longint vz;
            longint n;
            normal_out_t e;
            one = longint'(1) << FRAC;
            if (p.up_red == BG_RED && p.up_green == BG_GREEN && p.up_blue == BG_BLUE)
            begin
                // Background pixels point along (-1,-1,-1) before normalizing.
                vx = -one;
                vy = -one;
                vz = -one;
            end
            else
            begin
                vx = ((longint'(p.right_red) - longint'(p.left_red)) * one) / 255;
                vy = ((longint'(p.down_red) - longint'(p.up_red)) * one) / 255;
                vz = shade_root(p.up_red) + shade_root(p.down_red)
                   + shade_root(p.left_red) + shade_root(p.right_red);
            end
            n = longint'(floor_sqrt(longint'(vx * vx + vy * vy + vz * vz)));
            e.normal_x_byte = encode_component(vx, n);
            e.normal_y_byte = encode_component(vy, n);
            e.normal_z_byte = encode_component(vz, n);
            owed_normals.push_back(e);
        endfunction

        function void check_normal(normal_out_t got);
            normal_out_t e;
            if (owed_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal beat: x=%0d y=%0d z=%0d",
                             got.normal_x_byte, got.normal_y_byte, got.normal_z_byte);
                return;
            end
            e = owed_normals.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("normal mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                             e.normal_x_byte, e.normal_y_byte, e.normal_z_byte,
                             got.normal_x_byte, got.normal_y_byte, got.normal_z_byte);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    pixel_in_t   pixel;
    logic        valid;
    normal_out_t normal;

    normal_scoreboard sb;

    four_light_shading_to_normal_pixel_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .valid  (valid),
        .normal (normal)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watch both channels at each rising edge. The inputs are driven with
    // nonblocking assignments, so the values seen here are the ones the core
    // samples at this same edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_pixel(pixel);
        if (rst_n && valid)
            sb.check_normal(normal);
    end

    // Present one pixel and hold it until the core takes the beat. Start is
    // left high so that back-to-back pixels follow one another without a gap.
    task automatic send_pixel(pixel_in_t p);
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a random burst of idle cycles.
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
    endtask

    // Hold off the next pixel until the core has delivered every owed normal.
    task automatic drain_normals();
        start <= 1'b0;
        @(posedge clk);
        while (sb.owed_normals.size() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_in_t make_pixel(logic [7:0] ur, logic [7:0] ug, logic [7:0] ub,
                                             logic [7:0] dr, logic [7:0] lr, logic [7:0] rr);
        pixel_in_t p;
        p.up_red    = ur;
        p.up_green  = ug;
        p.up_blue   = ub;
        p.down_red  = dr;
        p.left_red  = lr;
        p.right_red = rr;
        return p;
    endfunction

    // Reds at the ends of their range are where the root terms and the
    // clamp behave most differently, so favor them now and then.
    function automatic logic [7:0] pick_red();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(250, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p = make_pixel(pick_red(), 8'($urandom), 8'($urandom),
                       pick_red(), pick_red(), pick_red());
        // About one pixel in eight is background or one bit off from it.
        case ($urandom_range(0, 15))
            0:
            begin
                p.up_red   = BG_RED;
                p.up_green = BG_GREEN;
                p.up_blue  = BG_BLUE;
            end
            1:
            begin
                p.up_red   = BG_RED;
                p.up_green = BG_GREEN;
                p.up_blue  = BG_BLUE ^ (8'd1 << $urandom_range(0, 7));
            end
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        pixel_in_t directed[$];
        int tail_wait;
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels: extremes, background and its near misses, the
        // all-white pixel whose vector is zero, and the strongest tilts.
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd17, 8'd200, 8'd99));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd254, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd1, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255));
        directed.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0));
        directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd254));
        directed.push_back(make_pixel(8'd254, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255));
        directed.push_back(make_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
        directed.push_back(make_pixel(8'd1, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1));
        foreach (directed[i])
            send_pixel(directed[i]);

        // Let the pipeline run dry once before the random part.
        drain_normals();

        // Random pixels. Gaps come in bursts early on; the last stretch
        // runs back to back so the core sees one pixel per clock.
        for (int i = 0; i < 600; i++)
        begin
            if (i < 480 && $urandom_range(0, 3) == 0)
                idle_burst();
            if (i == 300)
                drain_normals();
            send_pixel(random_pixel());
        end
        start <= 1'b0;

        // Wait for every owed normal, then a full pipeline depth more so
        // that any stray extra beat is caught.
        tail_wait = 0;
        while (sb.owed_normals.size() != 0 && tail_wait < 20 * LATENCY)
        begin
            @(posedge clk);
            tail_wait++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (sb.mismatches == 0 && sb.owed_normals.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
